[rtl/dsrm_pkg.sv]
//------------------------------------------------------------------------------
// dsrm_pkg
// Shared widths, datapath operation codes and controller/datapath structs.
//------------------------------------------------------------------------------
`default_nettype none

package dsrm_pkg;

   localparam int DATA_W     = 64;
   localparam int MAX_DIGITS = 19;
   localparam int BCD_DIGITS = 20;   // 2^64 needs 20 decimal digits
   localparam int LEN_W      = 5;
   localparam int CNT_W      = 6;    // counts the 64 bit-serial steps
   localparam int K_W        = 6;    // common factors of two, at most 63

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_BCD_STEP,
      OP_SHUF_INIT,
      OP_SHUF_STEP,
      OP_GCD_INIT_NT,
      OP_GCD_INIT_QG,
      OP_GCD_STEP,
      OP_G_SAVE,
      OP_DIV_INIT_NG,
      OP_DIV_INIT_TG,
      OP_DIV_INIT_QD,
      OP_DIV_STEP,
      OP_Q_SAVE
   } dsrm_op_type;

   typedef struct packed {
      dsrm_op_type op;
      logic        out_load;
      logic        match;
   } dsrm_cmd_type;

   typedef struct packed {
      logic step_last;   // bit-serial counter at its final step
      logic shuf_last;   // last output digit of the shuffle
      logic gcd_done;    // one gcd operand reached zero
      logic pre_fail;    // n mod 10 = 0, n = t or g <= 1
      logic d_le1;       // running gcd result <= 1
      logic q_le1;       // cofactor reduced to <= 1
   } dsrm_stat_type;

endpackage

`default_nettype wire

[rtl/dsrm_req_if.sv]
//------------------------------------------------------------------------------
// dsrm_req_if
// Candidate channel: valid/ready with one 64-bit number.
//------------------------------------------------------------------------------
`default_nettype none

interface dsrm_req_if;
   import dsrm_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

[rtl/dsrm_rsp_if.sv]
//------------------------------------------------------------------------------
// dsrm_rsp_if
// Result channel: match flag, shuffled value and gcd.
//------------------------------------------------------------------------------
`default_nettype none

interface dsrm_rsp_if;
   import dsrm_pkg::*;
   logic              valid;
   logic              ready;
   logic              is_match;
   logic [DATA_W-1:0] shuffled;
   logic [DATA_W-1:0] common_divisor;
   modport source (output valid, output is_match, output shuffled,
                   output common_divisor, input ready);
   modport sink   (input valid, input is_match, input shuffled,
                   input common_divisor, output ready);
endinterface

`default_nettype wire

[rtl/dsrm_csr_if.sv]
//------------------------------------------------------------------------------
// dsrm_csr_if
// Register write channel for the digit count.
//------------------------------------------------------------------------------
`default_nettype none

interface dsrm_csr_if;
   import dsrm_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] digit_count;
   modport source (output valid, output digit_count, input ready);
   modport sink   (input valid, input digit_count, output ready);
endinterface

`default_nettype wire

[rtl/dsrm_datapath.sv]
//------------------------------------------------------------------------------
// dsrm_datapath
// Digit split, shuffle, binary gcd, restoring divider and result register.
//------------------------------------------------------------------------------
`default_nettype none

module dsrm_datapath
   import dsrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dsrm_cmd_type       cmd,
   output dsrm_stat_type           stat,
   input  wire logic [DATA_W-1:0]  candidate,
   input  wire logic               csr_we,
   input  wire logic [LEN_W-1:0]   csr_data,
   output logic                    out_match,
   output logic [DATA_W-1:0]       out_shuffled,
   output logic [DATA_W-1:0]       out_gcd
);

   logic [LEN_W-1:0]        len_ff, len_in;
   logic [DATA_W-1:0]       n_ff, n_in, t_ff, t_in, g_ff, g_in, q_ff, q_in;
   logic [DATA_W-1:0]       bin_ff, bin_in;
   logic [4*BCD_DIGITS-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]        j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [DATA_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [DATA_W-1:0]       dq_ff, dq_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic                    om_ff;
   logic [DATA_W-1:0]       ot_ff, og_ff;

   logic [LEN_W-1:0]        eff_len, src, idx;
   logic [4*BCD_DIGITS-1:0] bcd_adj;
   logic [DATA_W-1:0]       gres;
   logic [DATA_W:0]         r2;
   logic [3:0]              dig;

   // register value clamped to 1..MAX_DIGITS
   always_comb begin
      if (len_ff == '0)
         eff_len = LEN_W'(1);
      else if (len_ff > LEN_W'(MAX_DIGITS))
         eff_len = LEN_W'(MAX_DIGITS);
      else
         eff_len = len_ff;
   end

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5)
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         else
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
      end
   end

   assign src  = j_ff[0] ? hi_ff : lo_ff;
   assign idx  = eff_len - LEN_W'(1) - src;
   assign dig  = bcd_ff[4*idx +: 4];
   assign gres = (a_ff | b_ff) << k_ff;
   assign r2   = {rem_ff, dq_ff[DATA_W-1]};

   always_comb begin
      len_in = csr_we ? csr_data : len_ff;
      n_in   = n_ff;   t_in  = t_ff;   g_in  = g_ff;   q_in = q_ff;
      bin_in = bin_ff; bcd_in = bcd_ff; cnt_in = cnt_ff;
      j_in   = j_ff;   lo_in = lo_ff;  hi_in = hi_ff;
      a_in   = a_ff;   b_in  = b_ff;   k_in  = k_ff;
      dq_in  = dq_ff;  rem_in = rem_ff; dvs_in = dvs_ff;
      unique case (cmd.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            n_in   = candidate;
            bin_in = candidate;
            bcd_in = '0;
            cnt_in = '0;
         end
         OP_BCD_STEP: begin
            {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_SHUF_INIT: begin
            t_in  = '0;
            j_in  = '0;
            lo_in = '0;
            hi_in = eff_len - LEN_W'(1);
         end
         OP_SHUF_STEP: begin
            t_in = (t_ff << 3) + (t_ff << 1) + DATA_W'(dig);
            j_in = j_ff + LEN_W'(1);
            if (j_ff[0])
               hi_in = hi_ff - LEN_W'(1);
            else
               lo_in = lo_ff + LEN_W'(1);
         end
         OP_GCD_INIT_NT: begin
            a_in = n_ff; b_in = t_ff; k_in = '0;
         end
         OP_GCD_INIT_QG: begin
            a_in = q_ff; b_in = g_ff; k_in = '0;
         end
         OP_GCD_STEP: begin
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + K_W'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         OP_G_SAVE: begin
            g_in = gres;
         end
         OP_DIV_INIT_NG: begin
            dq_in = n_ff; dvs_in = g_ff; rem_in = '0; cnt_in = '0;
         end
         OP_DIV_INIT_TG: begin
            dq_in = t_ff; dvs_in = g_ff; rem_in = '0; cnt_in = '0;
         end
         OP_DIV_INIT_QD: begin
            dq_in = q_ff; dvs_in = gres; rem_in = '0; cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (r2 >= {1'b0, dvs_ff}) begin
               rem_in = DATA_W'(r2 - {1'b0, dvs_ff});
               dq_in  = {dq_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = r2[DATA_W-1:0];
               dq_in  = {dq_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_Q_SAVE: begin
            q_in = dq_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(MAX_DIGITS);
      end else begin
         len_ff <= len_in;
      end
      n_ff <= n_in;  t_ff <= t_in;  g_ff <= g_in;  q_ff <= q_in;
      bin_ff <= bin_in; bcd_ff <= bcd_in; cnt_ff <= cnt_in;
      j_ff <= j_in;  lo_ff <= lo_in; hi_ff <= hi_in;
      a_ff <= a_in;  b_ff <= b_in;  k_ff <= k_in;
      dq_ff <= dq_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      if (cmd.out_load) begin
         om_ff <= cmd.match;
         ot_ff <= t_ff;
         og_ff <= g_ff;
      end
   end

   assign stat.step_last = (cnt_ff == {CNT_W{1'b1}});
   assign stat.shuf_last = (j_ff == eff_len - LEN_W'(1));
   assign stat.gcd_done  = (a_ff == '0) || (b_ff == '0);
   assign stat.pre_fail  = (bcd_ff[3:0] == 4'd0) || (n_ff == t_ff)
                           || (g_ff <= DATA_W'(1));
   assign stat.d_le1     = (gres <= DATA_W'(1));
   assign stat.q_le1     = (q_ff <= DATA_W'(1));

   assign out_match    = om_ff;
   assign out_shuffled = ot_ff;
   assign out_gcd      = og_ff;

endmodule

`default_nettype wire

[rtl/dsrm_ctrl.sv]
//------------------------------------------------------------------------------
// dsrm_ctrl
// Sequencer: digit split, shuffle, gcd, then the radical reduction loops.
//------------------------------------------------------------------------------
`default_nettype none

module dsrm_ctrl
   import dsrm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dsrm_stat_type stat,
   output dsrm_cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_BCD    = 12'b0000_0000_0010,
      S_SHINIT = 12'b0000_0000_0100,
      S_SHUF   = 12'b0000_0000_1000,
      S_GINIT  = 12'b0000_0001_0000,
      S_GCD1   = 12'b0000_0010_0000,
      S_CHECK  = 12'b0000_0100_0000,
      S_DIV    = 12'b0000_1000_0000,
      S_QSAVE  = 12'b0001_0000_0000,
      S_PWTEST = 12'b0010_0000_0000,
      S_GCD2   = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;     // 0: cofactor n/g, 1: cofactor t/g
   logic      match_ff, match_in;
   logic      full_ff, full_in;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      match_in     = match_ff;
      cmd.op       = OP_NOP;
      cmd.out_load = 1'b0;
      cmd.match    = match_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_BCD;
            end
         end
         S_BCD: begin
            cmd.op = OP_BCD_STEP;
            if (stat.step_last) state_in = S_SHINIT;
         end
         S_SHINIT: begin
            cmd.op   = OP_SHUF_INIT;
            state_in = S_SHUF;
         end
         S_SHUF: begin
            cmd.op = OP_SHUF_STEP;
            if (stat.shuf_last) state_in = S_GINIT;
         end
         S_GINIT: begin
            cmd.op   = OP_GCD_INIT_NT;
            state_in = S_GCD1;
         end
         S_GCD1: begin
            if (stat.gcd_done) begin
               cmd.op   = OP_G_SAVE;
               state_in = S_CHECK;
            end else begin
               cmd.op = OP_GCD_STEP;
            end
         end
         S_CHECK: begin
            side_in = 1'b0;
            if (stat.pre_fail) begin
               match_in = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_DIV_INIT_NG;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (stat.step_last) state_in = S_QSAVE;
         end
         S_QSAVE: begin
            cmd.op   = OP_Q_SAVE;
            state_in = S_PWTEST;
         end
         S_PWTEST: begin
            if (!stat.q_le1) begin
               cmd.op   = OP_GCD_INIT_QG;
               state_in = S_GCD2;
            end else if (!side_ff) begin
               side_in  = 1'b1;
               cmd.op   = OP_DIV_INIT_TG;
               state_in = S_DIV;
            end else begin
               match_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_GCD2: begin
            if (!stat.gcd_done) begin
               cmd.op = OP_GCD_STEP;
            end else if (stat.d_le1) begin
               match_in = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_DIV_INIT_QD;
               state_in = S_DIV;
            end
         end
         S_DONE: begin
            if (!full_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load)
         full_in = 1'b1;
      else if (rsp_ready)
         full_in = 1'b0;
      else
         full_in = full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
      side_ff  <= side_in;
      match_ff <= match_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = full_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_BCD))
      else $error("accepted transaction did not start digit split");
   a_load_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!full_ff || rsp_ready))
      else $error("result register overwritten");
   a_prefail_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && stat.pre_fail) |=> (state_ff == S_DONE && !match_ff))
      else $error("trivial reject did not finish");
   a_match_only_side1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PWTEST && stat.q_le1 && !side_ff) |=> (state_ff == S_DIV))
      else $error("t cofactor check skipped");
`endif

endmodule

`default_nettype wire

[rtl/digit_shuffle_radical_match_top.sv]
//------------------------------------------------------------------------------
// digit_shuffle_radical_match_top
// Outer-in digit shuffle of a candidate and equal-radical test against it.
//------------------------------------------------------------------------------
// Usage notes:
//  - req_ch carries one 64-bit candidate per transaction; rsp_ch returns one
//    transaction per candidate: match flag, shuffled value, gcd.
//  - csr_ch writes the digit count L (always ready); write only while idle.
//    Reset value 19; 0 acts as 1, values above 19 act as 19.
//  - One candidate at a time. Per candidate: bit-serial binary to BCD, the
//    shuffle, a binary gcd and, when the cheap checks pass, exact divisions
//    (one quotient bit per cycle) plus a binary gcd for each reduction round.
//  - Result register sits between the datapath and rsp_ch, so a new candidate
//    is taken while a finished result still waits for the receiver. If the
//    receiver stalls, the next result is held in the sequencer until the
//    register frees up.
//  - Synchronous active-high reset returns to idle with no result pending.
//------------------------------------------------------------------------------
`default_nettype none

module digit_shuffle_radical_match_top
   import dsrm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   dsrm_req_if.sink    req_ch,
   dsrm_rsp_if.source  rsp_ch,
   dsrm_csr_if.sink    csr_ch
);

   dsrm_cmd_type  cmd;
   dsrm_stat_type stat;

   // register port never stalls
   assign csr_ch.ready = 1'b1;

   dsrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsrm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .candidate    (req_ch.candidate),
      .csr_we       (csr_ch.valid),
      .csr_data     (csr_ch.digit_count),
      .out_match    (rsp_ch.is_match),
      .out_shuffled (rsp_ch.shuffled),
      .out_gcd      (rsp_ch.common_divisor)
   );

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Testbench for digit_shuffle_radical_match_top. It predicts, for each candidate
// taken, the outer-in digit shuffle, the gcd and the equal-radical flag, then
// checks every result transaction in order. Both channels get random gaps, and
// one long receiver stall fills the block up.
//------------------------------------------------------------------------------
module tb;
   import dsrm_pkg::*;

   typedef struct {
      bit              is_match;
      bit [DATA_W-1:0] shuffled;
      bit [DATA_W-1:0] common_divisor;
   } radical_result_t;

   logic clock;
   logic reset;

   dsrm_req_if req_ch ();
   dsrm_rsp_if rsp_ch ();
   dsrm_csr_if csr_ch ();

   digit_shuffle_radical_match_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state: the digit count register as last written
   bit [LEN_W-1:0]  digit_count_reg;
   radical_result_t pending_results[$];

   int   mismatch_count;
   int   results_seen;
   int   matches_seen;
   int   candidates_sent;
   int   rsp_hold_cycles;   // long hold-off, set by a test or drawn at random
   bit   rsp_stalls_on;     // random stalls on the result side
   bit   req_gaps_on;       // random gaps on the candidate side

   //---------------------------------------------------------------------------
   // Clock and run limit
   //---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("timeout: %0d results outstanding", pending_results.size());
      $display("TB_ERROR");
      $finish;
   end

   //---------------------------------------------------------------------------
   // Predictor
   //---------------------------------------------------------------------------
   function automatic int unsigned active_digits(bit [LEN_W-1:0] reg_val);
      if (reg_val < 1) return 1;
      if (reg_val > MAX_DIGITS) return MAX_DIGITS;
      return reg_val;
   endfunction

   function automatic bit [63:0] gcd64(bit [63:0] a, bit [63:0] b);
      bit [63:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // true when every prime dividing q also divides g
   function automatic bit primes_divide(bit [63:0] q, bit [63:0] g);
      bit [63:0] d;
      while (q > 1) begin
         d = gcd64(q, g);
         if (d <= 1) return 1'b0;
         q = q / d;
      end
      return 1'b1;
   endfunction

   function automatic bit [63:0] outer_in_shuffle(bit [63:0] n, int unsigned len);
      int unsigned digit[MAX_DIGITS];
      int unsigned lo, hi, src;
      bit [63:0]   x, t;
      x = n;
      t = 0;
      for (int i = 0; i < len; i++) begin
         digit[i] = 32'(x % 64'd10);
         x = x / 64'd10;
      end
      lo = 0;
      hi = len - 1;
      // left position p is digit index len-1-p
      for (int j = 0; j < len; j++) begin
         if (j % 2 == 0) begin
            src = lo;
            lo++;
         end else begin
            src = hi;
            hi--;
         end
         t = t * 64'd10 + 64'(digit[len - 1 - src]);
      end
      return t;
   endfunction

   function automatic radical_result_t predict_radical(bit [63:0] n);
      radical_result_t r;
      r.shuffled       = outer_in_shuffle(n, active_digits(digit_count_reg));
      r.common_divisor = gcd64(n, r.shuffled);
      r.is_match       = 1'b0;
      if (n % 64'd10 != 0 && n != r.shuffled && r.common_divisor > 1)
         r.is_match = primes_divide(n / r.common_divisor, r.common_divisor) &&
                      primes_divide(r.shuffled / r.common_divisor, r.common_divisor);
      return r;
   endfunction

   function automatic bit [63:0] pow10(int unsigned k);
      bit [63:0] p;
      p = 1;
      repeat (k) p = p * 64'd10;
      return p;
   endfunction

   //---------------------------------------------------------------------------
   // Result side: ready driver and checker
   //---------------------------------------------------------------------------
   initial begin
      int r;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (rsp_hold_cycles > 0) begin
            // long hold-off, counted here cycle by cycle
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (!rsp_stalls_on || r < 70) begin
            rsp_ch.ready <= 1'b1;
         end else if (r < 96) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles = $urandom_range(5, 40);
         end
      end
   end

   always @(posedge clock) begin
      radical_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result transaction", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (want.is_match) matches_seen++;
            if (rsp_ch.is_match !== want.is_match ||
                rsp_ch.shuffled !== want.shuffled ||
                rsp_ch.common_divisor !== want.common_divisor) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch exp m=%0b t=%0d g=%0d got m=%b t=%0d g=%0d",
                           $realtime, want.is_match, want.shuffled,
                           want.common_divisor, rsp_ch.is_match,
                           rsp_ch.shuffled, rsp_ch.common_divisor);
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Candidate and register drivers
   //---------------------------------------------------------------------------
   // Offers one candidate and waits for the transaction; valid stays high so a
   // following send with no gap keeps the channel busy.
   task automatic send_candidate(bit [63:0] n);
      int r;
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.candidate <= n;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results = {pending_results, predict_radical(n)};
      candidates_sent++;
      r = $urandom_range(0, 99);
      if (req_gaps_on && r >= 60) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (r < 95 ? $urandom_range(0, 2) : $urandom_range(10, 60))
            @(negedge clock);
      end
   endtask

   // Waits until every result is back, then writes the digit count.
   task automatic write_digit_count(bit [LEN_W-1:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.digit_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      digit_count_reg = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Hunts for a candidate below 10^len whose shuffle has the same radical;
   // falls back to the last try when none turns up.
   function automatic bit [63:0] matching_candidate(int unsigned len);
      bit [63:0] n;
      for (int i = 0; i < 3000; i++) begin
         n = rand64() % pow10(len);
         if (predict_radical(n).is_match) return n;
      end
      return n;
   endfunction

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------
   // Edge values under the reset digit count of 19.
   task automatic test_extremes();
      send_candidate(64'd0);
      send_candidate(64'd1);
      send_candidate(64'd9999999999999999999);
      send_candidate(64'd1000000000000000000);
      send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
      send_candidate(64'h8000_0000_0000_0000);
      send_candidate(64'd1234567890123456789);
      send_candidate(64'd5555555555555555555);
      send_candidate(64'd1234567891234567891);
   endtask

   // Out-of-range register codes, wide candidates, short lengths, tens.
   task automatic test_register_edges();
      write_digit_count(5'd0);       // acts as one digit
      send_candidate(64'd7);
      send_candidate(64'd123456);    // higher digits dropped from the shuffle
      send_candidate(64'd20);
      write_digit_count(5'd31);      // clamps to 19
      send_candidate(64'd9876543210987654321);
      send_candidate(64'd1111111111111111110);
      write_digit_count(5'd20);
      send_candidate(64'd1212121212121212121);
      write_digit_count(5'd2);       // two digits keep their order: n == t
      send_candidate(64'd12);
      send_candidate(64'd1200);      // multiple of ten, wider than L
      write_digit_count(5'd3);
      send_candidate(64'd123);
      send_candidate(matching_candidate(3));
      send_candidate(matching_candidate(4));
      write_digit_count(5'd4);
      send_candidate(matching_candidate(4));
   endtask

   // Receiver holds off for a long stretch while candidates keep coming.
   task automatic test_backpressure();
      write_digit_count(5'd6);
      rsp_hold_cycles = 3000;
      req_gaps_on     = 1'b0;
      for (int i = 0; i < 8; i++)
         send_candidate(i % 2 ? matching_candidate(6) : rand64() % pow10(6));
      req_gaps_on = 1'b1;
   endtask

   // Random candidates across several digit counts: mostly numbers with
   // at most L digits, many hunted to match, plus full-width noise.
   task automatic test_random_phases();
      bit [LEN_W-1:0] settings[] = '{1, 19, 3, 5, 7, 4, 12, 0, 31, 8, 2, 6};
      bit [LEN_W-1:0] len;
      int             r;
      for (int p = 0; p < 14; p++) begin
         len = p < settings.size() ? settings[p] : LEN_W'($urandom_range(0, 31));
         write_digit_count(len);
         // alternate quiet stretches with random stalls
         rsp_stalls_on = p % 3 != 0;
         req_gaps_on   = p % 4 != 1;
         for (int i = 0; i < 30; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40 && active_digits(len) <= 8)
               send_candidate(matching_candidate(active_digits(len)));
            else if (r < 80)
               send_candidate(rand64() % pow10(active_digits(len)));
            else if (r < 88)
               send_candidate((rand64() % pow10(active_digits(len))) * 64'd10);
            else
               send_candidate(rand64());
         end
      end
   endtask

   //---------------------------------------------------------------------------
   // Sequence
   //---------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.candidate   = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.digit_count = '0;
      digit_count_reg    = 5'd19;
      rsp_hold_cycles    = 0;
      rsp_stalls_on      = 1'b1;
      req_gaps_on        = 1'b1;
      mismatch_count     = 0;
      results_seen       = 0;
      matches_seen       = 0;
      candidates_sent    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_register_edges();
      test_backpressure();
      test_random_phases();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("covered %0d candidates, %0d results, %0d matches, 21 register writes",
               candidates_sent, results_seen, matches_seen);
      $display("digit counts 0..31 incl. clamping, long receiver stall, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/dsrm_pkg.sv
rtl/dsrm_req_if.sv
rtl/dsrm_rsp_if.sv
rtl/dsrm_csr_if.sv
rtl/dsrm_datapath.sv
rtl/dsrm_ctrl.sv
rtl/digit_shuffle_radical_match_top.sv
verif/tb.sv
